FILE: rtl/ps2mct_pkg.sv
// Shared types, constants and arithmetic helpers for the PS/2 mouse cursor tracker.
package ps2mct_pkg;

  localparam int COORD_WIDTH = 8;
  localparam int SUM_W = ((COORD_WIDTH > 8) ? COORD_WIDTH : 8) + 2;

  localparam logic [7:0] MAX_COLUMN_RESET = 8'd79;
  localparam logic [7:0] MAX_ROW_RESET    = 8'd24;

  localparam logic REG_MAX_COLUMN = 1'b0;
  localparam logic REG_MAX_ROW    = 1'b1;

  localparam int FLAG_X_SIGN = 4;
  localparam int FLAG_Y_SIGN = 5;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_STORE,
    OP_MOVE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } cmd_t;

  // 9-bit signed movement halved, rounding toward zero
  function automatic logic signed [7:0] half_move(input logic [7:0] low, input logic neg);
    logic signed [9:0] t;
    t = $signed({neg, neg, low}) + $signed({9'd0, neg});
    return t[8:1];
  endfunction

  // add a signed step to a position and clamp to 0..min(limit, coord max)
  function automatic logic [COORD_WIDTH-1:0] clamp_axis(
    input logic [COORD_WIDTH-1:0] pos,
    input logic signed [7:0]      step,
    input logic [7:0]             limit
  );
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W-1:0] top;
    logic signed [SUM_W-1:0] cmax;
    logic signed [SUM_W-1:0] lim;
    cmax = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, {COORD_WIDTH{1'b1}}});
    lim  = $signed({{(SUM_W-8){1'b0}}, limit});
    top  = (lim > cmax) ? cmax : lim;
    v = $signed({{(SUM_W-COORD_WIDTH){1'b0}}, pos})
      + $signed({{(SUM_W-8){step[7]}}, step});
    if (v < 0) begin
      v = '0;
    end
    if (v > top) begin
      v = top;
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

FILE: rtl/ps2mct_if.sv
// Handshake channel interfaces for controller events and cursor results.
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic       data_ready;
  logic       from_aux;
  logic [7:0] data_byte;

  modport source (output valid, output data_ready, output from_aux, output data_byte,
                  input ready);
  modport sink   (input valid, input data_ready, input from_aux, input data_byte,
                  output ready);
endinterface

interface ps2mct_out_if;
  logic       valid;
  logic       ready;
  logic       byte_taken;
  logic       packet_done;
  logic [7:0] cursor_column;
  logic [7:0] cursor_row;

  modport source (output valid, output byte_taken, output packet_done,
                  output cursor_column, output cursor_row, input ready);
  modport sink   (input valid, input byte_taken, input packet_done,
                  input cursor_column, input cursor_row, output ready);
endinterface

FILE: rtl/ps2_mouse_cursor_tracker_top.sv
// Top level of the PS/2 mouse cursor tracker: config registers and front/queue/back.
//
// Channels: in_ch (sink) carries one controller event per beat: data_ready,
// from_aux and data_byte. out_ch (source) returns exactly one result beat per
// input beat, in order: byte_taken, packet_done and the cursor position after
// that event. A byte counts only when data_ready and from_aux are both set;
// three counted bytes (flags, X, Y) form a packet that moves the cursor.
// Movement is halved toward zero, X added to the column, Y subtracted from
// the row, each axis clamped to 0..max.
// Config: cfg_we/cfg_index/cfg_data write max_column (index 0) or max_row
// (index 1); write only while no result is outstanding.
// Path: an input beat is written into the queue, and the result register loads
// from the queue when the result register is empty or its result is being taken.
// Throughput: one beat per cycle, back to back, while out_ch is ready. In
// steady flow one queue slot is in use; a stall on out_ch fills the other
// slot, so the queue is full and in_ch.ready drops until results drain.
// Reset (rst, synchronous): cursor at 0,0, packet assembly at the flags byte,
// queue and output empty, max_column 79, max_row 24.
module ps2_mouse_cursor_tracker_top (
  input  logic        clk,
  input  logic        rst,
  ps2mct_in_if.sink   in_ch,
  ps2mct_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic             push;
  logic             full;
  logic             not_empty;
  logic             pop;
  ps2mct_pkg::cmd_t front_cmd;
  ps2mct_pkg::cmd_t back_cmd;
  logic [7:0]       max_column;
  logic [7:0]       max_row;

  // clamp limits
  always_ff @(posedge clk) begin
    if (rst) begin
      max_column <= ps2mct_pkg::MAX_COLUMN_RESET;
      max_row    <= ps2mct_pkg::MAX_ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2mct_pkg::REG_MAX_COLUMN: max_column <= cfg_data;
        ps2mct_pkg::REG_MAX_ROW:    max_row    <= cfg_data;
      endcase
    end
  end

  ps2mct_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .cmd   (front_cmd)
  );

  ps2mct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .pop_cmd   (back_cmd)
  );

  ps2mct_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .cmd        (back_cmd),
    .pop        (pop),
    .max_column (max_column),
    .max_row    (max_row),
    .out_ch     (out_ch)
  );

endmodule

FILE: rtl/ps2mct_front.sv
// Front end: filters controller bytes and assembles three-byte packets into commands.
module ps2mct_front (
  input  logic                clk,
  input  logic                rst,
  ps2mct_in_if.sink           in_ch,
  input  logic                full,
  output logic                push,
  output ps2mct_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    POS_FLAGS,
    POS_DX,
    POS_DY
  } pos_t;

  pos_t       byte_position;
  pos_t       byte_position_next;
  logic [7:0] flags_byte;
  logic [7:0] dx_byte;
  logic       take;

  assign in_ch.ready = !full;
  assign push = in_ch.valid && !full;
  assign take = in_ch.data_ready && in_ch.from_aux;

  always_comb begin
    cmd.op = ps2mct_pkg::OP_SKIP;
    cmd.dx = ps2mct_pkg::half_move(dx_byte, flags_byte[ps2mct_pkg::FLAG_X_SIGN]);
    cmd.dy = ps2mct_pkg::half_move(in_ch.data_byte, flags_byte[ps2mct_pkg::FLAG_Y_SIGN]);
    byte_position_next = byte_position;
    if (take) begin
      case (byte_position)
        POS_DX: begin
          cmd.op = ps2mct_pkg::OP_STORE;
          byte_position_next = POS_DY;
        end
        POS_DY: begin
          cmd.op = ps2mct_pkg::OP_MOVE;
          byte_position_next = POS_FLAGS;
        end
        default: begin
          cmd.op = ps2mct_pkg::OP_STORE;
          byte_position_next = POS_DX;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FLAGS;
    end else if (push) begin
      byte_position <= byte_position_next;
    end
  end

  // packet bytes: written before being read within a packet
  always_ff @(posedge clk) begin
    if (push && take) begin
      if (byte_position == POS_DX) begin
        dx_byte <= in_ch.data_byte;
      end else if (byte_position != POS_DY) begin
        flags_byte <= in_ch.data_byte;
      end
    end
  end

endmodule

FILE: rtl/ps2mct_queue.sv
// Two-entry command queue between front and back ends.
module ps2mct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ps2mct_pkg::cmd_t push_cmd,
  output logic             full,
  output logic             not_empty,
  input  logic             pop,
  output ps2mct_pkg::cmd_t pop_cmd
);

  ps2mct_pkg::cmd_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/ps2mct_back.sv
// Back end: applies packet movement to the cursor and holds the result register.
module ps2mct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             not_empty,
  input  ps2mct_pkg::cmd_t cmd,
  output logic             pop,
  input  logic [7:0]       max_column,
  input  logic [7:0]       max_row,
  ps2mct_out_if.source     out_ch
);

  logic [ps2mct_pkg::COORD_WIDTH-1:0] column_position;
  logic [ps2mct_pkg::COORD_WIDTH-1:0] row_position;
  logic [ps2mct_pkg::COORD_WIDTH-1:0] column_next;
  logic [ps2mct_pkg::COORD_WIDTH-1:0] row_next;
  logic                               is_move;
  logic signed [7:0]                  neg_dy;

  assign pop     = not_empty && (!out_ch.valid || out_ch.ready);
  assign is_move = (cmd.op == ps2mct_pkg::OP_MOVE);
  // dy is -128..127 after halving, so its negation fits in 8 bits except -128
  assign neg_dy  = -cmd.dy;

  always_comb begin
    column_next = column_position;
    row_next    = row_position;
    if (is_move) begin
      column_next = ps2mct_pkg::clamp_axis(column_position, cmd.dx, max_column);
      if (cmd.dy == -8'sd128) begin
        // subtracting -128 adds 128, outside the signed step range:
        // add 127 first, then 1 more with the real clamp limit
        row_next = ps2mct_pkg::clamp_axis(
          ps2mct_pkg::clamp_axis(row_position, 8'sd127, 8'hFF), 8'sd1, max_row);
      end else begin
        row_next = ps2mct_pkg::clamp_axis(row_position, neg_dy, max_row);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid    <= 1'b0;
      column_position <= '0;
      row_position    <= '0;
    end else begin
      if (pop) begin
        out_ch.valid    <= 1'b1;
        column_position <= column_next;
        row_position    <= row_next;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.byte_taken    <= (cmd.op != ps2mct_pkg::OP_SKIP);
      out_ch.packet_done   <= is_move;
      out_ch.cursor_column <= 8'(column_next);
      out_ch.cursor_row    <= 8'(row_next);
    end
  end

endmodule
